FILE: rtl/core/sha256sh_pkg.sv
// ----------------------------------------------------------------------------
// sha256sh_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256sh_pkg;

  typedef logic [31:0] word_t;

  // control from the byte sequencer to the compression core
  typedef struct packed {
    logic start;    // run one compression on the block buffer
    logic restart;  // load the initial chaining values
  } ctl_t;

  // status from the compression core
  typedef struct packed {
    logic busy;
    logic done;     // one-cycle pulse, chaining words updated
  } stat_t;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [6:0] LEN_POS     = 7'd56;
  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [2:0] LAST_WORD   = 3'd7;
  localparam logic [4:0] SCHED_WORDS = 5'd16;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [5:0] LAST_BYTE   = 6'd63;

  function automatic word_t init_chain(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sha256sh_buf.sv
// ----------------------------------------------------------------------------
// sha256sh_buf
// 64-byte block buffer: byte-wide write port, big-endian word read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256sh_buf (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire  [5:0]           wr_addr,
  input  wire  [7:0]           wr_byte,
  input  wire  [3:0]           rd_addr,
  output sha256sh_pkg::word_t  rd_data
);
  import sha256sh_pkg::*;

  word_t mem [16];

  // byte 0 of a word sits in the top lane
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/sha256sh_core.sv
// ----------------------------------------------------------------------------
// sha256sh_core
// Compression core: one shared round unit iterated over 64 rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256sh_core (
  input  wire                  clk,
  input  wire                  rst,
  input  sha256sh_pkg::ctl_t   ctl,
  output sha256sh_pkg::stat_t  stat,
  output logic [3:0]           rd_addr,
  input  sha256sh_pkg::word_t  rd_data,
  output sha256sh_pkg::word_t  chain [8]
);
  import sha256sh_pkg::*;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_ROUND,
    CS_ADD
  } core_state_t;

  core_state_t state;
  logic [5:0]  cnt;
  logic        done;
  word_t       work  [8];
  word_t       sched [16];

  word_t t1, t2, w_new;

  // sched[0] holds the word for the current round
  always_comb begin
    t1 = work[7] + big_sigma1(work[4]) + ((work[4] & work[5]) ^ (~work[4] & work[6]))
         + round_k(cnt) + sched[0];
    t2 = big_sigma0(work[0])
         + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
    w_new = small_sigma1(sched[14]) + sched[9] + small_sigma0(sched[1]) + sched[0];
  end

  assign rd_addr   = cnt[3:0];
  assign stat.busy = (state != CS_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= init_chain(3'(i));
      end
    end else begin
      // one-cycle pulse right after the chaining add
      done <= (state == CS_ADD);
      case (state)
        CS_IDLE: begin
          cnt <= '0;
          if (ctl.restart) begin
            for (int i = 0; i < 8; i++) begin
              chain[i] <= init_chain(3'(i));
            end
          end
          if (ctl.start) begin
            for (int i = 0; i < 8; i++) begin
              work[i] <= chain[i];
            end
            state <= CS_LOAD;
          end
        end
        CS_LOAD: begin
          // read data trails the address by the buffer's output register
          if (cnt != '0) begin
            for (int i = 0; i < 15; i++) begin
              sched[i] <= sched[i+1];
            end
            sched[15] <= rd_data;
          end
          if (cnt == 6'(SCHED_WORDS)) begin
            cnt   <= '0;
            state <= CS_ROUND;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        CS_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            sched[i] <= sched[i+1];
          end
          sched[15] <= w_new;
          work[7] <= work[6];
          work[6] <= work[5];
          work[5] <= work[4];
          work[4] <= work[3] + t1;
          work[3] <= work[2];
          work[2] <= work[1];
          work[1] <= work[0];
          work[0] <= t1 + t2;
          if (cnt == LAST_ROUND) begin
            state <= CS_ADD;
          end
          cnt <= cnt + 6'd1;
        end
        CS_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          state <= CS_IDLE;
        end
        default: begin
          state <= CS_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, digest returned as eight 32-bit beats.
// ----------------------------------------------------------------------------
// usage:
//   input channel s_axis: one message byte per beat in tdata, tuser high when
//   the byte belongs to the message (low only on the closing beat of an empty
//   message), tlast on the final beat of a message
//   output channel m_axis: eight beats per message, digest word 0 first,
//   word index in tdata above the word, tlast on word 7
// timing:
//   byte beats are taken one per cycle while tready is high; the beat that
//   fills a 64-byte block holds tready low while the block compresses (start,
//   buffer reads, rounds, chaining add, hand-back), a stall set by the single
//   shared round unit; after a tlast beat, padding writes one buffer byte per
//   cycle except while a block compresses, and the first digest beat follows
//   the final compression, of an extra block when the length spills into one
// reset and stall:
//   rst (synchronous) clears the byte count and bit length and loads the
//   initial chaining values; the digest beat is held in an output register
//   while tready on m_axis is low, and no input is taken until all eight
//   beats have gone out; the block then starts a fresh message
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tuser,   // [0] has_byte
  input  wire         s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha256sh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLK_WAIT,
    ST_PAD80,
    ST_PADZERO,
    ST_PADZ_WAIT,
    ST_PADLEN,
    ST_FIN_WAIT,
    ST_EMIT
  } seq_state_t;

  seq_state_t  state;
  logic [5:0]  fill;       // bytes held in the block buffer
  logic [63:0] msg_bits;   // message length in bits, wraps
  logic [6:0]  pos;        // padding write position, up to a full block
  logic        pend_last;  // tlast seen on the beat that filled a block
  logic [2:0]  idx;        // digest word on the output
  logic [2:0]  idx_next;
  ctl_t        ctl;
  ctl_t        ctl_next;
  stat_t       stat;

  // buffer write and read ports, chaining words
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;
  logic [3:0]  rd_addr;
  word_t       rd_data;
  word_t       chain [8];

  logic s_accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign idx_next      = idx + 3'd1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill;
    wr_byte = s_axis_tdata;
    case (state)
      ST_IDLE: begin
        wr_en = s_accept && s_axis_tuser;
      end
      ST_PAD80: begin
        wr_en   = 1'b1;
        wr_byte = PAD_BYTE;
      end
      ST_PADZERO: begin
        wr_en   = (pos != LEN_POS) && (pos != BLOCK_BYTES);
        wr_addr = pos[5:0];
        wr_byte = 8'h00;
      end
      ST_PADLEN: begin
        // length goes out most significant byte first
        wr_en   = 1'b1;
        wr_addr = pos[5:0];
        wr_byte = msg_bits[{~pos[2:0], 3'b000} +: 8];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // compression start: full block, extra padding block, or length written; restart after the last digest word
  always_comb begin
    ctl_next.start   = ((state == ST_IDLE) && s_accept && s_axis_tuser
                        && (fill == LAST_BYTE))
                       || ((state == ST_PADZERO) && (pos == BLOCK_BYTES))
                       || ((state == ST_PADLEN) && (pos[2:0] == LAST_WORD));
    ctl_next.restart = (state == ST_EMIT) && m_axis_tready && (idx == LAST_WORD);
  end

  sha256sh_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_byte (wr_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sha256sh_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .stat    (stat),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .chain   (chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl           <= '0;
      state         <= ST_IDLE;
      fill          <= '0;
      msg_bits      <= '0;
      pos           <= '0;
      pend_last     <= 1'b0;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
    end else begin
      ctl <= ctl_next;
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_axis_tuser) begin
              fill     <= fill + 6'd1;
              msg_bits <= msg_bits + 64'd8;
            end
            if (s_axis_tuser && (fill == LAST_BYTE)) begin
              // block full: compress before anything else
              pend_last <= s_axis_tlast;
              state     <= ST_BLK_WAIT;
            end else if (s_axis_tlast) begin
              state <= ST_PAD80;
            end
          end
        end
        ST_BLK_WAIT: begin
          if (stat.done) begin
            state <= pend_last ? ST_PAD80 : ST_IDLE;
          end
        end
        ST_PAD80: begin
          pos   <= {1'b0, fill} + 7'd1;
          state <= ST_PADZERO;
        end
        ST_PADZERO: begin
          if (pos == LEN_POS) begin
            state <= ST_PADLEN;
          end else if (pos == BLOCK_BYTES) begin
            // no room for the length: extra block
            state <= ST_PADZ_WAIT;
          end else begin
            pos <= pos + 7'd1;
          end
        end
        ST_PADZ_WAIT: begin
          if (stat.done) begin
            pos   <= '0;
            state <= ST_PADZERO;
          end
        end
        ST_PADLEN: begin
          pos <= pos + 7'd1;
          if (pos[2:0] == LAST_WORD) begin
            state <= ST_FIN_WAIT;
          end
        end
        ST_FIN_WAIT: begin
          if (stat.done) begin
            idx           <= '0;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'b0, 3'd0, chain[0]};
            m_axis_tlast  <= 1'b0;
            state         <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            if (idx == LAST_WORD) begin
              m_axis_tvalid <= 1'b0;
              m_axis_tlast  <= 1'b0;
              fill          <= '0;
              msg_bits      <= '0;
              state         <= ST_IDLE;
            end else begin
              idx          <= idx_next;
              m_axis_tdata <= {5'b0, idx_next, chain[idx_next]};
              m_axis_tlast <= (idx_next == LAST_WORD);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // no input is taken while a digest is still going out
  a_ready_vs_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while digest pending");

  // the core never runs while bytes can land in the buffer
  a_busy_blocks_in: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !s_axis_tready)
    else $error("input ready during compression");

  // tlast marks exactly the eighth digest word
  a_tlast_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == LAST_WORD)))
    else $error("tlast does not match word index");

  // padding position never runs past one block
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PADZERO) |-> (pos <= BLOCK_BYTES))
    else $error("padding position out of range");

  // a compression start is always answered by a busy core
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> stat.busy)
    else $error("compression start lost");
`endif

endmodule

`default_nettype wire
